// ----- rtl/core/tcm_pkg.sv -----
// Shared types and constants for the transitive closure matrix block.
// Item structs, kind codes, controller states and the controller-to-datapath command.
// No dependencies.
package tcm_pkg;

    localparam int KIND_W  = 2;
    localparam int ROW_W   = 5;
    localparam int BITS_W  = 32;
    localparam int COUNT_W = 6;

    localparam logic [KIND_W-1:0]  KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0]  KIND_RUN   = 2'd1;
    localparam logic [KIND_W-1:0]  KIND_READ  = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ROW_W-1:0]  row_index;
        logic [BITS_W-1:0] load_bits;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]  out_row;
        logic [BITS_W-1:0] closure_bits;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    typedef struct packed {
        logic               load_en;
        logic               read_en;
        logic               run_en;
        logic [ROW_W-1:0]   addr;
        logic [COUNT_W-1:0] active;
    } t_dp_cmd;

endpackage

// ----- rtl/core/tcm_datapath.sv -----
// Datapath of the transitive closure matrix: row registers, pivot select and
// output item register. Driven by tcm_ctrl through a t_dp_cmd; uses tcm_pkg.
module tcm_datapath
    import tcm_pkg::*;
#(
    parameter int ROWS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [ROW_W-1:0]  i_row_index,
    input  logic [BITS_W-1:0] i_load_bits,
    output t_out_item         o_out_item
);

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [ROWS-1:0] r_rows [ROWS];
    t_out_item       r_out;

    logic [RW-1:0]   addr_s;
    logic [ROWS-1:0] col_mask;
    logic [ROWS-1:0] sel_row;
    logic [ROWS-1:0] pivot;

    assign addr_s = i_cmd.addr[RW-1:0];

    // columns below the active count
    always_comb begin
        for (int j = 0; j < ROWS; j++) begin
            col_mask[j] = (COUNT_W'(j) < i_cmd.active);
        end
    end

    // single read port: pivot row during a run, addressed row otherwise
    assign sel_row = r_rows[addr_s];
    assign pivot   = sel_row & col_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ROWS; i++) begin
                r_rows[i] <= '0;
            end
        end else if (i_cmd.load_en) begin
            r_rows[addr_s] <= i_load_bits[ROWS-1:0] & col_mask;
        end else if (i_cmd.run_en) begin
            for (int i = 0; i < ROWS; i++) begin
                if ((COUNT_W'(i) < i_cmd.active) && r_rows[i][addr_s]) begin
                    r_rows[i] <= r_rows[i] | pivot;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else if (i_cmd.read_en) begin
            r_out.out_row      <= i_row_index;
            r_out.closure_bits <= BITS_W'(pivot);
        end
    end

    assign o_out_item = r_out;

endmodule

// ----- rtl/core/tcm_ctrl.sv -----
// Controller of the transitive closure matrix: node count register, handshakes,
// pivot counter and state machine. Commands tcm_datapath; uses tcm_pkg.
module tcm_ctrl
    import tcm_pkg::*;
#(
    parameter int ROWS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [ROW_W-1:0]   i_row_index,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata,
    output t_dp_cmd            o_cmd
);

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [COUNT_W-1:0] ROWS_C = COUNT_W'(ROWS);

    t_state             r_state, n_state;
    logic [RW-1:0]      r_pivot, n_pivot;
    logic               r_out_valid, n_out_valid;
    logic [COUNT_W-1:0] r_node_count;

    logic [COUNT_W-1:0] active;
    logic               idle;
    logic               accept;
    logic               row_ok;
    logic               last_pivot;

    // rows beyond the stored ones are always zero, so the count is clipped to them
    assign active = (r_node_count > ROWS_C) ? ROWS_C : r_node_count;

    assign idle       = (r_state == S_IDLE);
    assign o_in_stall = !idle || ((i_kind == KIND_READ) && r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;
    assign row_ok     = (COUNT_W'(i_row_index) < active);
    assign last_pivot = (COUNT_W'(r_pivot) == active - COUNT_W'(1));

    always_comb begin
        o_cmd.load_en = accept && (i_kind == KIND_LOAD) && row_ok;
        o_cmd.read_en = accept && (i_kind == KIND_READ) && row_ok;
        o_cmd.run_en  = (r_state == S_RUN);
        o_cmd.addr    = (r_state == S_RUN) ? ROW_W'(r_pivot) : i_row_index;
        o_cmd.active  = active;
    end

    always_comb begin
        n_state = r_state;
        n_pivot = r_pivot;
        unique case (r_state)
            S_IDLE: begin
                n_pivot = '0;
                if (accept && (i_kind == KIND_RUN) && (active != '0)) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                n_pivot = r_pivot + RW'(1);
                if (last_pivot) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.read_en) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pivot      <= '0;
            r_out_valid  <= 1'b0;
            r_node_count <= COUNT_RESET;
        end else begin
            r_state     <= n_state;
            r_pivot     <= n_pivot;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/core/transitive_closure_matrix.sv -----
// Boolean adjacency matrix with in-place transitive closure (Warshall).
// Input channel i_in_valid / i_in_item / o_in_stall, output channel
// o_out_valid / o_out_item / i_out_stall; an item moves when valid is high
// and stall is low. i_cfg_we writes the node count from i_cfg_wdata.
// A load item writes one row, columns at or above the node count cleared. The
// result item of a read item appears the cycle after acceptance, held in an
// output register until taken. A run item steps the pivot through every active
// node (up to MAX_NODES, at most 32) because one pivot row is broadcast to all
// row registers per cycle; no item is accepted during a run. Loads and reads
// with a row at or above the node count are dropped and give no result.
// A stalled result blocks only further reads; loads and runs still go in.
// Reset (synchronous, active low) clears every row at once and sets the node
// count to 32; the block takes items in the first cycle after reset.
module transitive_closure_matrix
    import tcm_pkg::*;
#(
    parameter int MAX_NODES = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_in_item           i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output t_out_item          o_out_item,
    input  logic               i_out_stall,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata
);

    // only 32 rows and columns can ever be loaded
    localparam int ROWS = (MAX_NODES < BITS_W) ? MAX_NODES : BITS_W;

    t_dp_cmd dp_cmd;

    tcm_ctrl #(
        .ROWS(ROWS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_in_item.kind),
        .i_row_index (i_in_item.row_index),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cmd       (dp_cmd)
    );

    tcm_datapath #(
        .ROWS(ROWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_row_index (i_in_item.row_index),
        .i_load_bits (i_in_item.load_bits),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTH
    logic in_read_accept;
    assign in_read_accept = i_in_valid && !o_in_stall && (i_in_item.kind == KIND_READ);

    // a result item only follows an accepted read
    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(in_read_accept))
        else $error("result item without an accepted read");

    // loads, runs and idle cycles leave the output register alone
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_read_accept |=> $stable(o_out_item))
        else $error("output item changed without a read");
`endif

endmodule

// ----- bench/tcm_checker.sv -----
// Scoreboard for the transitive closure matrix block: tracks the row store and node count
// from channel traffic, predicts every read result and compares it with the delivered item.
// Depends on tcm_pkg.
module tcm_checker
    import tcm_pkg::*;
#(
    parameter int NODES = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_in_item           i_in_item,
    input  logic               i_in_stall,
    input  logic               i_out_valid,
    input  t_out_item          i_out_item,
    input  logic               i_out_stall,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata,
    output int                 o_fail_count,
    output int                 o_pending
);

    logic [BITS_W-1:0]  model_rows [NODES];
    logic [COUNT_W-1:0] model_count = COUNT_RESET;
    t_out_item          expected_reads [$];
    int                 fails = 0;

    function automatic int active_nodes();
        return (model_count > NODES) ? NODES : int'(model_count);
    endfunction

    function automatic logic [BITS_W-1:0] col_mask(int n);
        logic [BITS_W:0] m;
        m = ({{BITS_W{1'b0}}, 1'b1} << n) - 1;
        return m[BITS_W-1:0];
    endfunction

    // pivot row is taken once per k, before it may grow through itself
    function automatic void warshall_close(int n);
        logic [BITS_W-1:0] m;
        logic [BITS_W-1:0] pivot;
        m = col_mask(n);
        for (int k = 0; k < n; k++) begin
            pivot = model_rows[k] & m;
            for (int i = 0; i < n; i++) begin
                if (model_rows[i][k]) model_rows[i] |= pivot;
            end
        end
    endfunction

    function automatic void apply_item(t_in_item it);
        int                n;
        logic [BITS_W-1:0] m;
        t_out_item         res;
        n = active_nodes();
        m = col_mask(n);
        case (it.kind)
            KIND_RUN: warshall_close(n);
            KIND_LOAD: begin
                if (it.row_index < n) model_rows[it.row_index] = it.load_bits & m;
            end
            KIND_READ: begin
                if (it.row_index < n) begin
                    res.out_row      = it.row_index;
                    res.closure_bits = model_rows[it.row_index] & m;
                    expected_reads   = {expected_reads, res};
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            foreach (model_rows[r]) model_rows[r] = '0;
            model_count = COUNT_RESET;
            expected_reads.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_reads.size() == 0) begin
                    $display("%0t: result item with none expected: got row %0d bits %h",
                             $time, i_out_item.out_row, i_out_item.closure_bits);
                    fails++;
                end else begin
                    want = expected_reads.pop_front();
                    if (i_out_item.out_row !== want.out_row) begin
                        $display("%0t: out_row mismatch: expected %0d, got %0d",
                                 $time, want.out_row, i_out_item.out_row);
                        fails++;
                    end
                    if (i_out_item.closure_bits !== want.closure_bits) begin
                        $display("%0t: closure_bits mismatch on row %0d: expected %h, got %h",
                                 $time, want.out_row, want.closure_bits,
                                 i_out_item.closure_bits);
                        fails++;
                    end
                end
            end
            if (i_cfg_we) model_count = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) apply_item(i_in_item);
        end
        o_fail_count <= fails;
        o_pending    <= expected_reads.size();
    end

endmodule

// ----- bench/tb_transitive_closure_matrix.sv -----
// Top of the transitive closure matrix bench: clock, reset, node count writes and item traffic.
// Instantiates the block and tcm_checker, which predicts and compares; gives the verdict.
// Depends on tcm_pkg, transitive_closure_matrix and tcm_checker.
module tb_transitive_closure_matrix;
    import tcm_pkg::*;

    localparam int NODES       = 32;
    localparam int IDLE_PCT    = 35;
    localparam int ITEM_TARGET = 400;
    localparam int SETTLE      = 48;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    t_in_item           in_item   = '0;
    logic               in_stall;
    logic               out_valid;
    t_out_item          out_item;
    logic               out_stall = 1'b1;
    logic               cfg_we    = 1'b0;
    logic [COUNT_W-1:0] cfg_wdata = '0;
    int                 fail_count;
    int                 pending;

    int                 idle_pct     = IDLE_PCT;
    logic               hold_req     = 1'b0;
    int                 useful_items = 0;
    logic [COUNT_W-1:0] cur_count    = COUNT_RESET;

    transitive_closure_matrix #(
        .MAX_NODES(NODES)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_item  (in_item),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out_item (out_item),
        .i_out_stall(out_stall),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    tcm_checker #(
        .NODES(NODES)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .i_in_stall  (in_stall),
        .i_out_valid (out_valid),
        .i_out_item  (out_item),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // result side: random stalls, plus one long hold-off when requested
    initial begin : rx_side
        logic held;
        held = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !held) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                out_stall <= ($urandom_range(99) < idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int active_of(logic [COUNT_W-1:0] c);
        return (c > NODES) ? NODES : int'(c);
    endfunction

    function automatic t_in_item mk(logic [KIND_W-1:0] k, logic [ROW_W-1:0] r,
                                    logic [BITS_W-1:0] b);
        t_in_item it;
        it.kind      = k;
        it.row_index = r;
        it.load_bits = b;
        return it;
    endfunction

    // mostly sparse rows so closures take several pivots to settle
    function automatic logic [BITS_W-1:0] graph_bits();
        case ($urandom_range(3))
            0:       return $urandom & $urandom & $urandom;
            1:       return 32'd1 << $urandom_range(31);
            2:       return $urandom;
            default: return $urandom & $urandom & $urandom & $urandom;
        endcase
    endfunction

    task automatic send_item(input t_in_item it);
        int n;
        n = active_of(cur_count);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        if (it.kind == KIND_RUN) begin
            if (n > 0) useful_items++;
        end else if (it.kind != KIND_UNUSED && it.row_index < n) begin
            useful_items++;
        end
    endtask

    // wait until every read result is in and any closure run has finished
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_count  = v;
    endtask

    task automatic random_group();
        int n;
        int loads;
        int reads;
        n = active_of(cur_count);
        if (n > 0 && $urandom_range(99) < 70) begin
            loads = int'($urandom_range((n < 8) ? n : 8, 1));
            for (int j = 0; j < loads; j++)
                send_item(mk(KIND_LOAD, ROW_W'($urandom_range(n - 1, 0)), graph_bits()));
            send_item(mk(KIND_RUN, ROW_W'($urandom), $urandom));
            if (n <= 8 || $urandom_range(9) == 0) begin
                for (int i = 0; i < n; i++) send_item(mk(KIND_READ, ROW_W'(i), $urandom));
            end else begin
                reads = int'($urandom_range(4, 1));
                for (int j = 0; j < reads; j++)
                    send_item(mk(KIND_READ, ROW_W'($urandom_range(n - 1, 0)), $urandom));
            end
        end else begin
            send_item(mk(KIND_W'($urandom_range(3)), ROW_W'($urandom_range(31)), $urandom));
        end
    endtask

    initial begin : stimulus
        logic [COUNT_W-1:0] plan [8];
        int                 phase;
        int                 goal;
        int                 groups;
        plan = '{6'd32, 6'd1, 6'd13, 6'd2, 6'd63, 6'd24, 6'd8, 6'd32};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // full size after reset: cleared store, all-ones row, short chain
        send_item(mk(KIND_READ, 5'd0, 32'hFFFF_FFFF));
        send_item(mk(KIND_LOAD, 5'd0, 32'hFFFF_FFFF));
        send_item(mk(KIND_LOAD, 5'd31, 32'h8000_0001));
        send_item(mk(KIND_READ, 5'd0, 32'h0));
        send_item(mk(KIND_READ, 5'd31, 32'h0));
        send_item(mk(KIND_LOAD, 5'd1, 32'h0000_0004));
        send_item(mk(KIND_LOAD, 5'd2, 32'h0000_0008));
        send_item(mk(KIND_LOAD, 5'd3, 32'h8000_0000));
        send_item(mk(KIND_UNUSED, 5'd5, 32'hFFFF_FFFF));
        send_item(mk(KIND_RUN, 5'd31, $urandom));
        send_item(mk(KIND_READ, 5'd1, 32'h0));
        send_item(mk(KIND_READ, 5'd3, 32'h0));
        send_item(mk(KIND_READ, 5'd31, 32'h0));

        // small count: out-of-range rows dropped, stale high columns hidden
        drain();
        write_count(6'd5);
        send_item(mk(KIND_LOAD, 5'd7, 32'hFFFF_FFFF));
        send_item(mk(KIND_READ, 5'd7, 32'h0));
        send_item(mk(KIND_READ, 5'd31, 32'h0));
        send_item(mk(KIND_READ, 5'd0, 32'h0));
        send_item(mk(KIND_LOAD, 5'd4, 32'hFFFF_FFFF));
        send_item(mk(KIND_RUN, 5'd0, 32'h0));
        send_item(mk(KIND_READ, 5'd1, 32'h0));

        // zero count: everything ignored
        drain();
        write_count(6'd0);
        send_item(mk(KIND_LOAD, 5'd0, 32'h0000_0001));
        send_item(mk(KIND_RUN, 5'd0, 32'h0));
        send_item(mk(KIND_READ, 5'd0, 32'h0));

        // count above the row limit saturates
        drain();
        write_count(6'd63);
        send_item(mk(KIND_READ, 5'd31, 32'h0));
        send_item(mk(KIND_READ, 5'd2, 32'h0));

        goal = useful_items + ITEM_TARGET;
        phase = 0;
        while (useful_items < goal) begin
            drain();
            write_count((phase < 8) ? plan[phase] : 6'($urandom_range(32, 1)));
            idle_pct = (phase == 2) ? 0 : IDLE_PCT;
            if (phase == 4) hold_req <= 1'b1;
            groups = 0;
            while (groups < 10 && useful_items < goal) begin
                random_group();
                groups++;
            end
            phase++;
        end

        drain();
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
